[sv/refcounted_page_allocator_defines.svh]
// Assertion macros shared by the page allocator.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// Next-cycle implication, checked outside reset.
`define RPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

[sv/rpa_pkg.sv]
`timescale 1ns / 1ps

package rpa_pkg;

    // Operation codes on the input
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_SEED  = 2'd2;

    // Status codes on the result
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;
    localparam logic [1:0] STATUS_ZERO  = 2'd3;

    // Configuration register indexes
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_TOP  = 1'b1;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] TOP_RESET  = 32'h0040_0000;

    // Classified command handed from the front to the back
    typedef enum logic [2:0] {
        K_ALLOC,
        K_FREE,
        K_SEED,
        K_BAD,
        K_NOP
    } kind_t;

    localparam int unsigned KIND_W = $bits(kind_t);

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } back_state_t;

endpackage

[sv/rpa_ram.sv]
`timescale 1ns / 1ps

module rpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/rpa_queue.sv]
`timescale 1ns / 1ps

module rpa_queue import rpa_pkg::*; #(
    parameter int unsigned WIDTH = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid,
    output logic             full
);

    localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;

    assign valid = (cnt_reg != '0);
    assign full  = (cnt_reg == QCW'(QUEUE_DEPTH));
    assign rdata = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[sv/rpa_front.sv]
`timescale 1ns / 1ps

module rpa_front import rpa_pkg::*; #(
    parameter int unsigned NUM_PAGES  = 1024,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  logic                         start,
    input  logic [1:0]                   operation,
    input  logic [ADDR_W-1:0]            address,
    input  logic [ADDR_W-1:0]            base_address,
    input  logic [ADDR_W-1:0]            top_address,
    input  logic                         clearing,
    input  logic                         queue_full,
    output logic                         busy,
    output logic                         push,
    output kind_t                        kind,
    output logic [$clog2(NUM_PAGES)-1:0] idx
);

    localparam int unsigned PW = $clog2(NUM_PAGES);

    logic [ADDR_W-1:0] diff;
    logic [ADDR_W:0]   page_num;
    logic              aligned;
    logic              in_range;

    // Hold off new items during the count clear and while the queue is full
    assign busy = clearing | queue_full;
    assign push = start & ~busy;

    // Check alignment and bounds, derive the page number
    assign diff     = address - base_address;
    assign page_num = {1'b0, diff} >> PAGE_SHIFT;
    assign aligned  = (address[PAGE_SHIFT-1:0] == '0);
    assign in_range = (address >= base_address) && (address < top_address)
                      && (page_num < (ADDR_W + 1)'(NUM_PAGES));
    assign idx      = page_num[PW-1:0];

    // Classify the operation
    always_comb
    begin
        unique case (operation)
            OP_ALLOC: kind = K_ALLOC;
            OP_FREE:  kind = (aligned && in_range) ? K_FREE : K_BAD;
            OP_SEED:  kind = (aligned && in_range) ? K_SEED : K_BAD;
            default:  kind = K_NOP;
        endcase
    end

endmodule

[sv/rpa_back.sv]
`timescale 1ns / 1ps

module rpa_back import rpa_pkg::*; #(
    parameter int unsigned NUM_PAGES  = 1024,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ADDR_W-1:0]                  base_address,
    input  logic                               q_valid,
    input  logic [KIND_W+$clog2(NUM_PAGES)-1:0] q_data,
    output logic                               q_pop,
    output logic                               clearing,
    output logic                               done,
    output logic [ADDR_W-1:0]                  page_address,
    output logic [1:0]                         status,
    output logic                               released,
    output logic [$clog2(NUM_PAGES+1)-1:0]     free_count
);

    localparam int unsigned PW = $clog2(NUM_PAGES);
    localparam int unsigned DW = $clog2(NUM_PAGES + 1);

    back_state_t       state_reg, state_next;
    logic [PW-1:0]     clr_reg, clr_next;
    logic [DW-1:0]     depth_reg, depth_next;
    kind_t             kind_reg, kind_next;
    logic [PW-1:0]     idx_reg, idx_next;
    logic              done_reg, done_next;
    logic [ADDR_W-1:0] page_reg, page_next;
    logic [1:0]        status_reg, status_next;
    logic              released_reg, released_next;

    kind_t             q_kind;
    logic [PW-1:0]     q_idx;
    logic [DW-1:0]     depth_m1;
    logic              stack_full;

    logic              cnt_we;
    logic [PW-1:0]     cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [COUNT_W-1:0] cnt_rdata;
    logic [COUNT_W-1:0] cnt_dec;
    logic              stk_we;
    logic [PW-1:0]     stk_rdata;
    logic [ADDR_W-1:0] page_off;

    assign q_kind     = kind_t'(q_data[PW +: KIND_W]);
    assign q_idx      = q_data[PW-1:0];
    assign depth_m1   = depth_reg - 1'b1;
    assign stack_full = (depth_reg >= DW'(NUM_PAGES));
    assign cnt_dec    = cnt_rdata - 1'b1;
    assign page_off   = ADDR_W'(stk_rdata) << PAGE_SHIFT;

    // Reference counts: read at the queue head, written in the execute cycle or by the clear
    rpa_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_PAGES)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (q_idx),
        .rdata (cnt_rdata)
    );

    // Free stack: read at the top entry, pushed at the depth
    rpa_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_PAGES)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[PW-1:0]),
        .wdata (idx_reg),
        .raddr (depth_m1[PW-1:0]),
        .rdata (stk_rdata)
    );

    // Sequence: clear counts, fetch an item, then execute it
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        depth_next    = depth_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        done_next     = 1'b0;
        page_next     = page_reg;
        status_next   = status_reg;
        released_next = released_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = idx_reg;
        cnt_wdata     = '0;
        stk_we        = 1'b0;
        q_pop         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                if (clr_reg == PW'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_kind;
                    idx_next   = q_idx;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next    = S_IDLE;
                done_next     = 1'b1;
                page_next     = '0;
                status_next   = STATUS_OK;
                released_next = 1'b0;
                unique case (kind_reg)
                    K_ALLOC:
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            cnt_we     = 1'b1;
                            cnt_waddr  = stk_rdata;
                            cnt_wdata  = COUNT_W'(1);
                            depth_next = depth_m1;
                            page_next  = base_address + page_off;
                        end
                    end
                    K_FREE:
                    begin
                        if (cnt_rdata == '0)
                        begin
                            status_next = STATUS_ZERO;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_dec;
                            if (cnt_dec == '0 && !stack_full)
                            begin
                                stk_we        = 1'b1;
                                depth_next    = depth_reg + 1'b1;
                                released_next = 1'b1;
                            end
                        end
                    end
                    K_SEED:
                    begin
                        // count goes to one and straight back to zero
                        cnt_we = 1'b1;
                        if (!stack_full)
                        begin
                            stk_we        = 1'b1;
                            depth_next    = depth_reg + 1'b1;
                            released_next = 1'b1;
                        end
                    end
                    K_BAD:
                    begin
                        status_next = STATUS_BAD;
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            depth_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        page_reg     <= page_next;
        status_reg   <= status_next;
        released_reg <= released_next;
    end

    assign clearing     = (state_reg == S_CLEAR);
    assign done         = done_reg;
    assign page_address = page_reg;
    assign status       = status_reg;
    assign released     = released_reg;
    assign free_count   = depth_reg;

endmodule

[sv/refcounted_page_allocator.sv]
`timescale 1ns / 1ps
`include "refcounted_page_allocator_defines.svh"

// Reference-counted page allocator. After reset the block zeroes every entry
// of the reference-count memory and holds busy high meanwhile; configuration
// writes are taken during that time. An item is taken when start is high and
// busy is low; it is checked and queued at once (two-entry queue) and the
// executer then works on it in a read step for the count and stack memories
// and a write-back step, and takes no new item before it has written the
// last one back. The result shows on done and the result ports for exactly
// one cycle, from registers loaded in the write-back step; it
// cannot be held off, so the receiver must take it in that cycle. busy also
// rises while the queue is full. free_count always shows the current number
// of free pages.
module refcounted_page_allocator import rpa_pkg::*; #(
    parameter int unsigned NUM_PAGES  = 1024,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [ADDR_W-1:0]              cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [ADDR_W-1:0]              address,
    output logic                           done,
    output logic [ADDR_W-1:0]              page_address,
    output logic [1:0]                     status,
    output logic                           released,
    output logic [$clog2(NUM_PAGES+1)-1:0] free_count
);

    localparam int unsigned PW = $clog2(NUM_PAGES);
    localparam int unsigned DW = $clog2(NUM_PAGES + 1);
    localparam int unsigned QW = KIND_W + PW;

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] top_reg, top_next;

    logic          clearing;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          f_push;
    kind_t         f_kind;
    logic [PW-1:0] f_idx;
    logic [QW-1:0] q_rdata;

    // Write the configuration registers
    always_comb
    begin
        base_next = base_reg;
        top_next  = top_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE: base_next = cfg_data;
                REG_TOP:  top_next  = cfg_data;
                default:  base_next = base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            top_reg  <= TOP_RESET;
        end
        else
        begin
            base_reg <= base_next;
            top_reg  <= top_next;
        end
    end

    rpa_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .start        (start),
        .operation    (operation),
        .address      (address),
        .base_address (base_reg),
        .top_address  (top_reg),
        .clearing     (clearing),
        .queue_full   (q_full),
        .busy         (busy),
        .push         (f_push),
        .kind         (f_kind),
        .idx          (f_idx)
    );

    rpa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata ({f_kind, f_idx}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid),
        .full  (q_full)
    );

    rpa_back #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_address (base_reg),
        .q_valid      (q_valid),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .done         (done),
        .page_address (page_address),
        .status       (status),
        .released     (released),
        .free_count   (free_count)
    );

    // Results never come back to back
    `RPA_ASSERT_NEXT(a_done_spacing, done, !done)
    // The free count never passes the number of pages
    `RPA_ASSERT_IMPLY(a_count_bound, done, free_count <= DW'(NUM_PAGES))
    // A release is always a successful operation
    `RPA_ASSERT_IMPLY(a_release_ok, done && released, status == STATUS_OK)
    // An empty report means the stack really is empty
    `RPA_ASSERT_IMPLY(a_empty_zero, done && status == STATUS_EMPTY,
        free_count == '0 && page_address == '0)

endmodule

[tb/refcounted_page_allocator_checker.sv]
`timescale 1ns / 1ps

// Watch the command, result and register ports of the page allocator, work out
// the outcome of every accepted item and compare each result with the oldest one.
module refcounted_page_allocator_checker import rpa_pkg::*; #(
    parameter int unsigned NUM_PAGES  = 1024,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [ADDR_W-1:0]              cfg_data,
    input  logic                           start,
    input  logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [ADDR_W-1:0]              address,
    input  logic                           done,
    input  logic [ADDR_W-1:0]              page_address,
    input  logic [1:0]                     status,
    input  logic                           released,
    input  logic [$clog2(NUM_PAGES+1)-1:0] free_count,
    output int                             failures,
    output int                             outstanding
);

    localparam int unsigned IDX_W = $clog2(NUM_PAGES);
    localparam int unsigned FC_W  = $clog2(NUM_PAGES+1);

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic [1:0]        status;
        logic              released;
        logic [FC_W-1:0]   free_count;
    } page_outcome_t;

    // Shadow of the allocator state
    logic [IDX_W-1:0]  stack_pages [NUM_PAGES];
    logic [7:0]        page_refs [NUM_PAGES];
    int unsigned       depth;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] top_reg;

    page_outcome_t expected_outcomes [$];

    // Apply one command to the shadow state and return the result it should give
    function automatic page_outcome_t apply_page_op(input logic [1:0] op,
                                                    input logic [ADDR_W-1:0] addr);
        page_outcome_t     res;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] page_off;
        logic [IDX_W-1:0]  idx;
        logic              managed;
        res      = '0;
        offset   = addr - base_reg;
        managed  = (addr[PAGE_SHIFT-1:0] == '0) && (addr >= base_reg) && (addr < top_reg)
                   && ((offset >> PAGE_SHIFT) < NUM_PAGES);
        idx      = offset[PAGE_SHIFT +: IDX_W];
        res.status = STATUS_OK;
        case (op)
            OP_ALLOC:
            begin
                if (depth == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    depth = depth - 1;
                    idx = stack_pages[depth];
                    page_refs[idx] = 8'd1;
                    page_off = ADDR_W'(idx);
                    res.page_address = base_reg + (page_off << PAGE_SHIFT);
                end
            end
            OP_FREE, OP_SEED:
            begin
                if (!managed)
                    res.status = STATUS_BAD;
                else
                begin
                    if (op == OP_SEED)
                        page_refs[idx] = 8'd1;
                    if (page_refs[idx] == 8'd0)
                        res.status = STATUS_ZERO;
                    else
                    begin
                        page_refs[idx] = page_refs[idx] - 8'd1;
                        // Push only at zero and only while the stack has room
                        if (page_refs[idx] == 8'd0 && depth < NUM_PAGES)
                        begin
                            stack_pages[depth] = idx;
                            depth = depth + 1;
                            res.released = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.free_count = FC_W'(depth);
        return res;
    endfunction

    // Compare one field and log a mismatch
    task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            failures = failures + 1;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Track registers, predict accepted items and check results
    always @(posedge clk or negedge rst_n)
    begin : watch
        page_outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                stack_pages[i] = '0;
                page_refs[i] = 8'd0;
            end
            depth = 0;
            base_reg = BASE_RESET;
            top_reg = TOP_RESET;
            expected_outcomes.delete();
            failures = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    failures = failures + 1;
                    $display("%0t: result with nothing expected, actual %h %0d %0d %0d",
                             $time, page_address, status, released, free_count);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("page_address", want.page_address, page_address);
                    check_field("status", ADDR_W'(want.status), ADDR_W'(status));
                    check_field("released", ADDR_W'(want.released), ADDR_W'(released));
                    check_field("free_count", ADDR_W'(want.free_count), ADDR_W'(free_count));
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_BASE)
                    base_reg = cfg_data;
                else
                    top_reg = cfg_data;
            end
            if (start && !busy)
                expected_outcomes.push_back(apply_page_op(operation, address));
            outstanding = expected_outcomes.size();
        end
    end

endmodule

[tb/tb_refcounted_page_allocator.sv]
`timescale 1ns / 1ps

module tb_refcounted_page_allocator;
    import rpa_pkg::*;

    localparam int unsigned NUM_PAGES  = 1024;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned FC_W       = $clog2(NUM_PAGES+1);

    // Operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    logic              start;
    logic              busy;
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic              done;
    logic [ADDR_W-1:0] page_address;
    logic [1:0]        status;
    logic              released;
    logic [FC_W-1:0]   free_count;

    int                failures;
    int                outstanding;
    int unsigned       idle_pct;
    logic [ADDR_W-1:0] cur_base;
    logic [ADDR_W-1:0] cur_top;

    refcounted_page_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .address      (address),
        .done         (done),
        .page_address (page_address),
        .status       (status),
        .released     (released),
        .free_count   (free_count)
    );

    refcounted_page_allocator_checker #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .address      (address),
        .done         (done),
        .page_address (page_address),
        .status       (status),
        .released     (released),
        .free_count   (free_count),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] page_at(input int unsigned n);
        logic [ADDR_W-1:0] off;
        off = n;
        return cur_base + (off << PAGE_SHIFT);
    endfunction

    // Present one item, with random idle cycles ahead of it, and hold until taken
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        operation <= op;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic reconfigure(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top);
        drain();
        write_reg(REG_BASE, base);
        write_reg(REG_TOP, top);
        cur_base = base;
        cur_top = top;
    endtask

    // Mostly valid traffic on a few pages, the rest bad addresses and the unused code
    task automatic run_random(input int unsigned count, input int unsigned span);
        int unsigned pick;
        logic [1:0]  op;
        logic [ADDR_W-1:0] addr;
        for (int unsigned i = 0; i < count; i++)
        begin
            // Hold off until the block has caught up
            if (i == count / 2)
                drain();
            pick = $urandom_range(99);
            addr = $urandom;
            if (pick < 35)
                op = OP_ALLOC;
            else if (pick < 65)
            begin
                op = OP_FREE;
                addr = page_at($urandom_range(span - 1));
            end
            else if (pick < 80)
            begin
                op = OP_SEED;
                addr = page_at($urandom_range(span - 1));
            end
            else
            begin
                op = 2'($urandom_range(1, 3));
                case ($urandom_range(3))
                    0: addr = $urandom;
                    1: addr = page_at($urandom_range(span - 1))
                              | $urandom_range(1, (1 << PAGE_SHIFT) - 1);
                    2: addr = cur_base - ($urandom_range(1, 4) << PAGE_SHIFT);
                    default: addr = cur_top + ($urandom_range(0, 3) << PAGE_SHIFT);
                endcase
            end
            send_item(op, addr);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_BASE;
        cfg_data = '0;
        operation = OP_ALLOC;
        address = '0;
        idle_pct = 0;
        cur_base = BASE_RESET;
        cur_top = TOP_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Load the reset values while the count memory clears
        write_reg(REG_BASE, 32'h0000_0000);
        write_reg(REG_TOP, 32'h0040_0000);

        // Empty stack, zero count, seeding, bad addresses, unused code
        send_item(OP_ALLOC, 32'h0000_0000);
        send_item(OP_FREE, 32'h0000_0000);
        send_item(OP_SEED, 32'h0000_0000);
        send_item(OP_SEED, 32'h003F_F000);
        send_item(OP_FREE, 32'h0000_1001);
        send_item(OP_SEED, 32'h0040_0000);
        send_item(OP_FREE, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 32'h0000_0000);
        send_item(OP_ALLOC, 32'h0000_0000);
        send_item(OP_FREE, 32'h003F_F000);
        send_item(OP_FREE, 32'h003F_F000);
        // Same page twice on the stack
        send_item(OP_SEED, 32'h0000_0000);
        send_item(OP_SEED, 32'h0000_0000);
        send_item(OP_ALLOC, 32'h0000_0000);
        send_item(OP_ALLOC, 32'h0000_0000);
        send_item(OP_FREE, 32'h0000_0000);
        send_item(OP_FREE, 32'h0000_0000);

        // Raised base: below base, page number past the last page, moved base
        reconfigure(32'h1000_0000, 32'hFFFF_FFFF);
        idle_pct = 12;
        send_item(OP_SEED, 32'h0FFF_F000);
        send_item(OP_FREE, 32'h1040_0000);
        send_item(OP_SEED, 32'h103F_F000);
        send_item(OP_ALLOC, 32'h0000_0000);
        run_random(300, 16);

        // Base at the top of memory: page addresses past it wrap and are refused
        reconfigure(32'hFFFF_F000, 32'hFFFF_FFFF);
        idle_pct = 61;
        run_random(80, 2);

        // Empty range: every free and seed is refused
        reconfigure(32'h0000_0000, 32'h0000_0000);
        run_random(50, 8);

        // Eight pages, span reaching past the top
        reconfigure(32'h0080_0000, 32'h0080_8000);
        run_random(200, 10);

        // Fill the stack to the limit, then bring a count to zero while full
        reconfigure(32'h0000_0000, 32'h0040_0000);
        idle_pct = 0;
        repeat (NUM_PAGES + 6)
            send_item(OP_SEED, page_at($urandom_range(NUM_PAGES - 1)));
        send_item(OP_ALLOC, 32'h0000_0000);
        send_item(OP_SEED, page_at(5));
        send_item(OP_ALLOC, 32'h0000_0000);
        send_item(OP_SEED, page_at(7));
        send_item(OP_FREE, page_at(5));
        run_random(40, 32);

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
